@@ design/disciplined_clock_tick_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the disciplined clock tick block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DISCIPLINED_CLOCK_TICK_TOP_ASSERT_SVH
`define DISCIPLINED_CLOCK_TICK_TOP_ASSERT_SVH

// Next-cycle implication, masked while reset is asserted
`define DCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

// Same-cycle implication, masked while reset is asserted
`define DCT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication that also covers the reset cycles
`define DCT_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/dct_pkg.sv @@
// ----------------------------------------------------------------------------
// dct_pkg
// Types and constants shared by the disciplined clock tick block.
// ----------------------------------------------------------------------------
package dct_pkg;

    // Stream payload widths (fields packed from bit 0, tdata padded to bytes)
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // Item opcodes carried on s_tuser
    typedef enum logic [1:0] {
        OP_TICK          = 2'd0,
        OP_LOAD_RESIDUAL = 2'd1,
        OP_ARM_WRITE     = 2'd2,
        OP_READ_CLEAR    = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_SIZE      = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP_REMAINDER = 1'b1;

    // Reset values and fixed thresholds
    localparam logic [15:0]        STEP_SIZE_RESET = 16'd64;
    localparam logic [15:0]        FRACTION_RESET  = 16'd16384;
    localparam logic [15:0]        NEG_ABSORB_LOW  = 16'hFFF0;
    localparam logic signed [31:0] NEG_SLEW_LIMIT  = 32'shFFFF_0000;

    typedef struct packed {
        logic [15:0]        step_size;
        logic signed [10:0] step_remainder;
    } cfg_t;

    typedef struct packed {
        logic        write_calendar;
        logic [15:0] fraction;
        logic [15:0] seconds;
    } result_t;

endpackage

@@ design/dct_core.sv @@
// ----------------------------------------------------------------------------
// dct_core
// Clock state registers and the single-pass update for one item.
// ----------------------------------------------------------------------------
module dct_core #(
    parameter int TICKS_PER_SECOND = 1024,
    parameter int HALF_STEP        = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_en,
    input  dct_pkg::op_t         op,
    input  logic [31:0]          residual_value,
    input  logic [15:0]          write_delay,
    input  dct_pkg::cfg_t        cfg,
    output dct_pkg::result_t     result
);
    import dct_pkg::*;

    localparam logic [10:0]        TPS_RELOAD = 11'(TICKS_PER_SECOND);
    localparam logic [15:0]        HS16       = 16'(HALF_STEP);
    localparam logic signed [31:0] HS32       = 32'(HALF_STEP);

    logic [15:0] second_count_reg,    second_count_next;
    logic [15:0] fraction_count_reg,  fraction_count_next;
    logic [10:0] tick_in_second_reg,  tick_in_second_next;
    logic [31:0] residual_reg,        residual_next;
    logic        write_armed_reg,     write_armed_next;
    logic [15:0] write_countdown_reg, write_countdown_next;

    logic [10:0]        tis_dec;
    logic signed [12:0] t_pos;
    logic signed [12:0] t_neg;
    logic signed [12:0] rem_ext;
    logic [15:0]        step_trim;
    logic [15:0]        step_total;
    logic signed [31:0] res_s;
    logic               pos_slew;
    logic               neg_slew;
    logic [16:0]        frac_sum;

    // Tick-side arithmetic, shared by the update below
    always_comb begin
        tis_dec = tick_in_second_reg - 11'd1;
        t_pos   = {2'b00, tis_dec};
        t_neg   = -t_pos;
        rem_ext = {{2{cfg.step_remainder[10]}}, cfg.step_remainder};

        // remainder trim by one step on up to |step_remainder| ticks per second, skipped on the reload tick
        step_trim = cfg.step_size;
        if (tis_dec != 11'd0) begin
            if (t_pos <= rem_ext) begin
                step_trim = cfg.step_size + 16'd1;
            end else if (t_neg >= rem_ext) begin
                step_trim = cfg.step_size - 16'd1;
            end
        end

        // residual slew or absorb
        res_s    = $signed(residual_reg);
        pos_slew = res_s > HS32;
        neg_slew = res_s[31] && ((res_s < NEG_SLEW_LIMIT) ||
                                 (residual_reg[15:0] < NEG_ABSORB_LOW));
        if (pos_slew) begin
            step_total = step_trim + HS16;
        end else if (neg_slew) begin
            step_total = step_trim - HS16;
        end else begin
            step_total = step_trim + residual_reg[15:0];
        end

        frac_sum = {1'b0, fraction_count_reg} + {1'b0, step_total};
    end

    // Next state and result for the item in the input register
    always_comb begin
        second_count_next    = second_count_reg;
        fraction_count_next  = fraction_count_reg;
        tick_in_second_next  = tick_in_second_reg;
        residual_next        = residual_reg;
        write_armed_next     = write_armed_reg;
        write_countdown_next = write_countdown_reg;
        result.seconds        = second_count_reg;
        result.write_calendar = 1'b0;

        unique case (op)
            OP_TICK: begin
                if (write_armed_reg) begin
                    if (write_countdown_reg <= cfg.step_size) begin
                        result.write_calendar = 1'b1;
                        write_armed_next      = 1'b0;
                    end
                    write_countdown_next = write_countdown_reg - cfg.step_size;
                end
                tick_in_second_next = (tis_dec == 11'd0) ? TPS_RELOAD : tis_dec;
                if (pos_slew) begin
                    residual_next = residual_reg - HS32;
                end else if (neg_slew) begin
                    residual_next = residual_reg + HS32;
                end else begin
                    residual_next = 32'd0;
                end
                fraction_count_next = frac_sum[15:0];
                second_count_next   = second_count_reg + {15'd0, frac_sum[16]};
                result.seconds      = second_count_next;
            end
            OP_LOAD_RESIDUAL: begin
                residual_next = residual_value;
            end
            OP_ARM_WRITE: begin
                if (!write_armed_reg) begin
                    write_countdown_next = write_delay;
                    write_armed_next     = 1'b1;
                end
            end
            OP_READ_CLEAR: begin
                second_count_next = 16'd0;
            end
            default: begin
            end
        endcase
        result.fraction = fraction_count_next;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_count_reg    <= 16'd0;
            fraction_count_reg  <= FRACTION_RESET;
            tick_in_second_reg  <= TPS_RELOAD;
            residual_reg        <= 32'd0;
            write_armed_reg     <= 1'b0;
            write_countdown_reg <= 16'd0;
        end else if (item_en) begin
            second_count_reg    <= second_count_next;
            fraction_count_reg  <= fraction_count_next;
            tick_in_second_reg  <= tick_in_second_next;
            residual_reg        <= residual_next;
            write_armed_reg     <= write_armed_next;
            write_countdown_reg <= write_countdown_next;
        end
    end

endmodule

@@ design/disciplined_clock_tick_top.sv @@
// ----------------------------------------------------------------------------
// disciplined_clock_tick_top
// Disciplined software clock: input register, single-pass update, result
// register.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+-----------------------------------
//   s_      | in  | s_tvalid / s_tready | tuser op, tdata residual + delay
//   m_      | out | m_tvalid / m_tready | tdata seconds, fraction, write
//   cfg_    | in  | cfg_we              | cfg_addr, cfg_wdata (no read-back)
//
// One beat per cycle sustained while m_tready stays high; an accepted beat
// passes the input register, then the result register, before it can leave.
// The clock state updates as an item leaves the input register, so each
// item sees the state left by the one before it.
// Synchronous active-low reset; no clearing pass, ready right after reset.
// A stalled result register holds one beat while the input register takes
// another; s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module disciplined_clock_tick_top #(
    parameter int TICKS_PER_SECOND = 1024,
    parameter int HALF_STEP        = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // slave stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dct_pkg::S_TDATA_W-1:0]   s_tdata,   // residual_value[31:0], write_delay[47:32]
    input  logic [dct_pkg::S_TUSER_W-1:0]   s_tuser,   // op[1:0]
    // master stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dct_pkg::M_TDATA_W-1:0]   m_tdata,   // seconds[15:0], fraction[31:16],
                                                       // write_calendar[32], zero[39:33]
    // configuration write port
    input  logic                            cfg_we,
    input  logic [dct_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dct_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import dct_pkg::*;

    logic        in_valid_reg;
    op_t         in_op_reg;
    logic [31:0] in_residual_reg;
    logic [15:0] in_delay_reg;
    logic        m_valid_reg;
    result_t     m_result_reg;
    cfg_t        cfg_reg;
    result_t     core_result;
    logic        advance;
    logic        item_en;

    // Handshake: output register frees when empty or drained
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign item_en  = in_valid_reg && advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_size      <= STEP_SIZE_RESET;
            cfg_reg.step_remainder <= 11'sd0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_STEP_SIZE:      cfg_reg.step_size      <= cfg_wdata;
                CFG_STEP_REMAINDER: cfg_reg.step_remainder <= $signed(cfg_wdata[10:0]);
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg       <= op_t'(s_tuser[1:0]);
            in_residual_reg <= s_tdata[31:0];
            in_delay_reg    <= s_tdata[47:32];
        end
    end

    dct_core #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .HALF_STEP        (HALF_STEP)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_en        (item_en),
        .op             (in_op_reg),
        .residual_value (in_residual_reg),
        .write_delay    (in_delay_reg),
        .cfg            (cfg_reg),
        .result         (core_result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_en) begin
            m_result_reg <= core_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_result_reg.write_calendar,
                       m_result_reg.fraction, m_result_reg.seconds};

endmodule

@@ design/disciplined_clock_tick_checker.sv @@
// ----------------------------------------------------------------------------
// disciplined_clock_tick_checker
// Port-level checks on the disciplined clock tick block, bound to the top.
// ----------------------------------------------------------------------------
`include "disciplined_clock_tick_top_assert.svh"

module disciplined_clock_tick_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [dct_pkg::M_TDATA_W-1:0]   m_tdata    // seconds, fraction, write_calendar
);
    import dct_pkg::*;

    logic s_beat;
    assign s_beat = s_tvalid && s_tready;

    // Both pipeline registers empty after reset: no result, input open
    `DCT_ASSERT_RST(a_reset_empty, !aresetn, !m_tvalid && s_tready, "state not cleared by reset")

    // A result appears only for an input beat taken earlier
    `DCT_ASSERT_NEXT(a_no_spurious, !m_tvalid && !$past(s_beat), !m_tvalid, "result without input beat")

    // Padding bits of the result beat stay zero
    `DCT_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[39:33] == 7'd0, "nonzero padding on m_tdata")

    // A stalled result holds its payload
    `DCT_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind disciplined_clock_tick_top disciplined_clock_tick_checker u_dct_checker (.*);
